// ----- design/tmd_pkg.sv -----
// Shared types, constants and helpers for the face dedup table.
package tmd_pkg;

    localparam int MAX_FACES  = 64;
    localparam int COORD_BITS = 20;
    localparam int IDX_W      = $clog2(MAX_FACES);
    localparam int CNT_W      = $clog2(MAX_FACES + 1);
    localparam int OUT_IDX_W  = 6;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int ROOT_W     = CFG_W;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int CMP_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN   = 8'd1;
    localparam logic [CFG_W-1:0]     TOL_RESET     = 16'd205;
    localparam logic [CFG_W-1:0]     MIN_LEN_RESET = 16'd410;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        STAT_IGNORED = 2'd0,
        STAT_MATCHED = 2'd1,
        STAT_ADDED   = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        coord_t     first_end_x;
        coord_t     first_end_y;
        coord_t     first_end_z;
        coord_t     second_end_x;
        coord_t     second_end_y;
        coord_t     second_end_z;
    } s_item_t;

    typedef struct packed {
        status_t              status;
        logic [OUT_IDX_W-1:0] entry_index;
    } m_item_t;

    typedef struct packed {
        logic             start;
        coord_t           x0;
        coord_t           y0;
        coord_t           x1;
        coord_t           y1;
        logic [CFG_W-1:0] limit;
    } dist_req_t;

    typedef struct packed {
        logic              done;
        logic              below;
        logic [ROOT_W-1:0] root;
    } dist_res_t;

    function automatic logic [DIFF_W-1:0] absdiff(coord_t a, coord_t b);
        logic signed [DIFF_W:0] d;
        logic [DIFF_W:0]        m;
        d = (DIFF_W+1)'(a) - (DIFF_W+1)'(b);
        m = d[DIFF_W] ? -d : d;
        return m[DIFF_W-1:0];
    endfunction

    function automatic logic [OUT_IDX_W-1:0] to_out_idx(logic [CNT_W-1:0] v);
        logic [CNT_W+OUT_IDX_W-1:0] w;
        w = {{OUT_IDX_W{1'b0}}, v};
        return w[OUT_IDX_W-1:0];
    endfunction

endpackage

// ----- design/tmd_store.sv -----
// Face entry memory: one write port, one registered read port.
module tmd_store
    import tmd_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  s_item_t          wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output s_item_t          rd_data
);

    s_item_t mem_reg [MAX_FACES];
    s_item_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/tmd_dist.sv -----
// Shared planar distance unit: squares, limit test, bit-serial square root.
module tmd_dist
    import tmd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  dist_req_t req,
    output dist_res_t res
);

    typedef enum logic [1:0] {D_IDLE, D_SQ, D_SUM, D_ROOT} dstate_t;

    localparam int CNT_BITS = $clog2(ROOT_W);

    dstate_t             state_reg;
    logic [DIFF_W-1:0]   dx_reg, dy_reg;
    logic [CFG_W-1:0]    lim_reg;
    logic [SQ_W-1:0]     sqx_reg, sqy_reg;
    logic [RAD_W-1:0]    lim2_reg;
    logic [RAD_W-1:0]    n_reg, res_reg, bit_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                done_reg, below_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [SQ_W:0]       sum;
    logic [RAD_W:0]      trial;
    logic                take;
    logic [RAD_W-1:0]    res_next, n_next;

    always_comb begin
        sum      = (SQ_W+1)'(sqx_reg) + (SQ_W+1)'(sqy_reg);
        trial    = (RAD_W+1)'(res_reg) + (RAD_W+1)'(bit_reg);
        take     = (RAD_W+1)'(n_reg) >= trial;
        res_next = take ? (res_reg >> 1) + bit_reg : res_reg >> 1;
        n_next   = take ? n_reg - trial[RAD_W-1:0] : n_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (req.start) begin
                        dx_reg    <= absdiff(req.x0, req.x1);
                        dy_reg    <= absdiff(req.y0, req.y1);
                        lim_reg   <= req.limit;
                        state_reg <= D_SQ;
                    end
                end
                D_SQ: begin
                    sqx_reg   <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
                    sqy_reg   <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
                    lim2_reg  <= RAD_W'(lim_reg) * RAD_W'(lim_reg);
                    state_reg <= D_SUM;
                end
                D_SUM: begin
                    // below the limit squared means the root is below the limit
                    if (sum < (SQ_W+1)'(lim2_reg)) begin
                        below_reg <= 1'b1;
                        n_reg     <= sum[RAD_W-1:0];
                        res_reg   <= '0;
                        bit_reg   <= RAD_W'(1) << (RAD_W - 2);
                        cnt_reg   <= '0;
                        state_reg <= D_ROOT;
                    end else begin
                        below_reg <= 1'b0;
                        root_reg  <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                D_ROOT: begin
                    n_reg   <= n_next;
                    res_reg <= res_next;
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(ROOT_W - 1)) begin
                        root_reg  <= res_next[ROOT_W-1:0];
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign res.done  = done_reg;
    assign res.below = below_reg;
    assign res.root  = root_reg;

endmodule

// ----- design/tolerance_match_dedup_table.sv -----
// Top level of the face dedup table: sequencer, config registers, result register.
//
// Use: one face item enters on s_valid/s_ready (s_data), one result item leaves on
// m_valid/m_ready (m_data: status and entry_index). Configuration writes come on
// cfg_valid/cfg_ready with cfg_index (0 tolerance, 1 minimum length) and cfg_data;
// cfg_ready is always high, unknown indexes are dropped. Write config only when idle.
// Distances: one shared distance unit does every planar distance (operand, square,
// limit test, and 16 root steps when below the limit). The length check costs one distance.
// A stored entry whose colour differs or whose heights differ by more than the tolerance
// is skipped with no distance; otherwise it costs up to four distances, and the scan
// stops at the first match. s_ready is high only while the sequencer is idle. The
// finished result sits in an output register, so a new item is accepted while m_valid
// waits on a stalled m_ready; that item's result is then held until the register frees.
// Reset: entry count cleared, tolerance 205, minimum length 410, no result pending.
// Entries are never cleared; only entries below the count are read.
module tolerance_match_dedup_table
    import tmd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  s_item_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output m_item_t              m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LEN, ST_LEN_WAIT, ST_SCAN, ST_CHECK, ST_DIST, ST_DIST_WAIT, ST_RESULT
    } state_t;

    state_t           state_reg;
    s_item_t          item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [1:0]       dsel_reg;
    logic [ROOT_W-1:0] acc_reg;
    logic [CFG_W-1:0] tol_reg, min_len_reg;
    m_item_t          res_reg, m_data_reg;
    logic             m_valid_reg;

    s_item_t          ent;
    dist_req_t        dreq;
    dist_res_t        dres;
    logic             st_wr_en, st_rd_en;
    logic             colour_eq, z_ok;
    coord_t           zmin_e, zmax_e, zmin_n, zmax_n;
    logic [ROOT_W:0]  pair_sum;

    tmd_store u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (item_reg),
        .rd_en   (st_rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (ent)
    );

    tmd_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .res     (dres)
    );

    // store access happens only in the scan step
    assign st_rd_en = (state_reg == ST_SCAN) && (idx_reg != count_reg);
    assign st_wr_en = (state_reg == ST_SCAN) && (idx_reg == count_reg)
                      && (count_reg != CNT_W'(MAX_FACES));

    // colour and height window against the entry just read
    always_comb begin
        colour_eq = (ent.hue == item_reg.hue) && (ent.saturation == item_reg.saturation)
                    && (ent.brightness == item_reg.brightness);
        zmin_e = (ent.first_end_z < ent.second_end_z) ? ent.first_end_z : ent.second_end_z;
        zmax_e = (ent.first_end_z > ent.second_end_z) ? ent.first_end_z : ent.second_end_z;
        zmin_n = (item_reg.first_end_z < item_reg.second_end_z) ?
                 item_reg.first_end_z : item_reg.second_end_z;
        zmax_n = (item_reg.first_end_z > item_reg.second_end_z) ?
                 item_reg.first_end_z : item_reg.second_end_z;
        z_ok = (CMP_W'(absdiff(zmin_e, zmin_n)) <= CMP_W'(tol_reg))
               && (CMP_W'(absdiff(zmax_e, zmax_n)) <= CMP_W'(tol_reg));
        pair_sum = (ROOT_W+1)'(acc_reg) + (ROOT_W+1)'(dres.root);
    end

    // distance operands: own ends for the length check; crossed pair first, then straight
    always_comb begin
        dreq.start = (state_reg == ST_LEN) || (state_reg == ST_DIST);
        dreq.limit = tol_reg;
        dreq.x0    = ent.first_end_x;
        dreq.y0    = ent.first_end_y;
        dreq.x1    = item_reg.second_end_x;
        dreq.y1    = item_reg.second_end_y;
        if (state_reg == ST_LEN) begin
            dreq.limit = min_len_reg;
            dreq.x0    = item_reg.first_end_x;
            dreq.y0    = item_reg.first_end_y;
        end else begin
            case (dsel_reg)
                2'd1: begin
                    dreq.x0 = ent.second_end_x;
                    dreq.y0 = ent.second_end_y;
                    dreq.x1 = item_reg.first_end_x;
                    dreq.y1 = item_reg.first_end_y;
                end
                2'd2: begin
                    dreq.x1 = item_reg.first_end_x;
                    dreq.y1 = item_reg.first_end_y;
                end
                2'd3: begin
                    dreq.x0 = ent.second_end_x;
                    dreq.y0 = ent.second_end_y;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            tol_reg     <= TOL_RESET;
            min_len_reg <= MIN_LEN_RESET;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_TOLERANCE: tol_reg     <= cfg_data;
                    REG_MIN_LEN:   min_len_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            // the result step reloads the register itself
            if (m_valid_reg && m_ready && (state_reg != ST_RESULT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN: state_reg <= ST_LEN_WAIT;
                ST_LEN_WAIT: begin
                    if (dres.done) begin
                        if (dres.below) begin
                            res_reg.status      <= STAT_IGNORED;
                            res_reg.entry_index <= '0;
                            state_reg           <= ST_RESULT;
                        end else begin
                            idx_reg   <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (idx_reg == count_reg) begin
                        if (count_reg == CNT_W'(MAX_FACES)) begin
                            res_reg.status      <= STAT_FULL;
                            res_reg.entry_index <= '0;
                        end else begin
                            res_reg.status      <= STAT_ADDED;
                            res_reg.entry_index <= to_out_idx(count_reg);
                            count_reg           <= count_reg + 1'b1;
                        end
                        state_reg <= ST_RESULT;
                    end else begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (colour_eq && z_ok) begin
                        dsel_reg  <= 2'd0;
                        state_reg <= ST_DIST;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_DIST: state_reg <= ST_DIST_WAIT;
                ST_DIST_WAIT: begin
                    if (dres.done) begin
                        if (!dsel_reg[0]) begin
                            // first leg of a pairing; a leg at or over the limit kills it
                            if (dres.below) begin
                                acc_reg   <= dres.root;
                                dsel_reg  <= dsel_reg + 1'b1;
                                state_reg <= ST_DIST;
                            end else if (dsel_reg == 2'd0) begin
                                dsel_reg  <= 2'd2;
                                state_reg <= ST_DIST;
                            end else begin
                                idx_reg   <= idx_reg + 1'b1;
                                state_reg <= ST_SCAN;
                            end
                        end else if (dres.below && (pair_sum < (ROOT_W+1)'(tol_reg))) begin
                            res_reg.status      <= STAT_MATCHED;
                            res_reg.entry_index <= to_out_idx(idx_reg);
                            state_reg           <= ST_RESULT;
                        end else if (dsel_reg == 2'd1) begin
                            dsel_reg  <= 2'd2;
                            state_reg <= ST_DIST;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_FACES))
        else $error("entry count above table size");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        st_wr_en |-> (count_reg < CNT_W'(MAX_FACES)))
        else $error("append into a full table");

    a_dist_done: assert property (@(posedge aclk) disable iff (!aresetn)
        dres.done |-> (state_reg == ST_LEN_WAIT || state_reg == ST_DIST_WAIT))
        else $error("distance result with no waiting sequencer");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_rd_en |-> (idx_reg < count_reg))
        else $error("read of an unwritten entry");
`endif

endmodule
